/* hw/rtl/bld_pkg.sv */
`default_nettype none
package bld_pkg;

	localparam int DUTY_W       = 7;
	localparam int TICKS_W      = 8;
	localparam int PHASE_W      = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;
	localparam int COUNT_BITS_D = 8;

	localparam logic [DUTY_W-1:0]  PEAK_RST = DUTY_W'(55);
	localparam logic [TICKS_W-1:0] HOLD_RST = TICKS_W'(50);
	localparam logic [TICKS_W-1:0] DARK_RST = TICKS_W'(200);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_DUTY  = 2'd0,
		REG_HOLD_TICKS = 2'd1,
		REG_DARK_TICKS = 2'd2
	} cfg_reg_t;

	// Phase codes as they appear on the result channel.
	typedef enum logic [PHASE_W-1:0] {
		PH_UP   = 2'd0,
		PH_DOWN = 2'd1,
		PH_HOLD = 2'd2,
		PH_OFF  = 2'd3
	} phase_code_t;

	// Internal sequencer state.
	typedef enum logic [3:0] {
		ST_UP   = 4'b0001,
		ST_DOWN = 4'b0010,
		ST_HOLD = 4'b0100,
		ST_OFF  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  peak_duty;
		logic [TICKS_W-1:0] hold_ticks;
		logic [TICKS_W-1:0] dark_ticks;
	} bld_cfg_t;

	typedef struct packed {
		logic               duty_write;
		logic [DUTY_W-1:0]  duty;
		logic               running;
		logic [PHASE_W-1:0] phase;
	} bld_res_t;

	function automatic logic [PHASE_W-1:0] phase_code(input state_t st);
		logic [PHASE_W-1:0] code;
		case (st)
			ST_UP:   code = PH_UP;
			ST_DOWN: code = PH_DOWN;
			ST_HOLD: code = PH_HOLD;
			ST_OFF:  code = PH_OFF;
			default: code = PH_OFF;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/bld_cmd_if.sv */
`default_nettype none
interface bld_cmd_if;
	logic valid;
	logic ready;
	logic command;
	logic enable;

	modport source (output valid, output command, output enable, input ready);
	modport sink (input valid, input command, input enable, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bld_res_if.sv */
`default_nettype none
interface bld_res_if
	import bld_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               duty_write;
	logic [DUTY_W-1:0]  duty;
	logic               running;
	logic [PHASE_W-1:0] phase;

	modport source (output valid, output duty_write, output duty, output running,
		output phase, input ready);
	modport sink (input valid, input duty_write, input duty, input running,
		input phase, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bld_cfg_if.sv */
`default_nettype none
interface bld_cfg_if
	import bld_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bld_cfg.sv */
`default_nettype none
module bld_cfg
	import bld_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bld_cfg_if.sink   cfg,
	output bld_cfg_t  regs
);

	bld_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.peak_duty  <= PEAK_RST;
			regs_q.hold_ticks <= HOLD_RST;
			regs_q.dark_ticks <= DARK_RST;
		end else if (cfg.valid) begin
			// Writes to indexes beyond the register list are dropped.
			case (cfg.index)
				REG_PEAK_DUTY:  regs_q.peak_duty  <= cfg.data[DUTY_W-1:0];
				REG_HOLD_TICKS: regs_q.hold_ticks <= cfg.data[TICKS_W-1:0];
				REG_DARK_TICKS: regs_q.dark_ticks <= cfg.data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/bld_core.sv */
`default_nettype none
module bld_core
	import bld_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_D
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire logic     command,
	input  wire logic     enable,
	input  wire bld_cfg_t regs,
	output bld_res_t      res
);

	// Compare width covers both the counters and the 8-bit limits.
	localparam int CW = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

	logic                  run_q, run_d;
	state_t                st_q, st_d;
	logic [COUNT_BITS-1:0] rise_q, rise_d;
	logic [COUNT_BITS-1:0] fall_q, fall_d;
	logic [COUNT_BITS-1:0] hold_q, hold_d;
	logic [COUNT_BITS-1:0] dark_q, dark_d;
	logic                  wr;
	logic [DUTY_W-1:0]     duty;

	always_comb begin
		run_d  = run_q;
		st_d   = st_q;
		rise_d = rise_q;
		fall_d = fall_q;
		hold_d = hold_q;
		dark_d = dark_q;
		wr     = 1'b0;
		duty   = '0;
		if (command) begin
			if (enable && !run_q) begin
				run_d = 1'b1;
				st_d  = ST_UP;
			end else if (!enable && run_q) begin
				run_d  = 1'b0;
				rise_d = '0;
				fall_d = '0;
				hold_d = '0;
				dark_d = '0;
				st_d   = ST_OFF;
			end
		end else if (run_q) begin
			case (st_q)
				ST_UP: begin
					if (CW'(rise_q) <= CW'(regs.peak_duty)) begin
						wr     = 1'b1;
						duty   = rise_q[DUTY_W-1:0];
						rise_d = rise_q + COUNT_BITS'(1);
					end else begin
						rise_d = '0;
						fall_d = COUNT_BITS'(regs.peak_duty);
						st_d   = ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (CW'(hold_q) <= CW'(regs.hold_ticks)) begin
						hold_d = hold_q + COUNT_BITS'(1);
					end else begin
						hold_d = '0;
						st_d   = ST_DOWN;
					end
				end
				ST_DOWN: begin
					if (fall_q != '0) begin
						wr     = 1'b1;
						duty   = fall_q[DUTY_W-1:0];
						fall_d = fall_q - COUNT_BITS'(1);
					end else begin
						fall_d = COUNT_BITS'(regs.peak_duty);
						st_d   = ST_OFF;
					end
				end
				default: begin
					if (CW'(dark_q) <= CW'(regs.dark_ticks)) begin
						dark_d = dark_q + COUNT_BITS'(1);
					end else begin
						dark_d = '0;
						st_d   = ST_UP;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			st_q   <= ST_UP;
			rise_q <= '0;
			fall_q <= '0;
			hold_q <= '0;
			dark_q <= '0;
		end else if (step) begin
			run_q  <= run_d;
			st_q   <= st_d;
			rise_q <= rise_d;
			fall_q <= fall_d;
			hold_q <= hold_d;
			dark_q <= dark_d;
		end
	end

	assign res.duty_write = wr;
	assign res.duty       = duty;
	assign res.running    = run_d;
	assign res.phase      = phase_code(st_d);

endmodule
`default_nettype wire

/* hw/rtl/breathing_led_duty_sequencer.sv */
`default_nettype none
// Breathing LED duty sequencer. Each command transaction is either a step tick
// (command 0) or a run request (command 1, with enable) and produces exactly one
// result transaction carrying duty_write, duty, running and phase. While running,
// ticks walk a four-phase cycle: ramp up from 0 to peak_duty, hold for
// hold_ticks+1 ticks, ramp down from the peak to 1, then stay dark for
// dark_ticks+1 ticks; every phase change costs one tick with no duty write.
// The block takes one transaction per clock cycle unless the result port stalls.
// A transaction is captured in an input register, the next state is formed by a
// short compare and increment or decrement, and the result lands in the output
// register when that register is free and is offered from there; the state
// registers update in the cycle the result is registered, so a stalled result
// port simply holds the pipeline. Configuration writes are always accepted and
// take effect on the next tick; write them only while no transaction is in flight.
module breathing_led_duty_sequencer
	import bld_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_D
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bld_cmd_if.sink   cmd,
	bld_res_if.source res,
	bld_cfg_if.sink   cfg
);

	bld_cfg_t regs;
	bld_res_t res_next;
	bld_res_t res_q;
	logic     valid_s1;
	logic     command_s1;
	logic     enable_s1;
	logic     out_valid_q;
	logic     advance;

	bld_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// The held transaction moves into the output register whenever that
	// register is empty or being drained this cycle.
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			command_s1 <= cmd.command;
			enable_s1  <= cmd.enable;
		end
	end

	bld_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.command (command_s1),
		.enable  (enable_s1),
		.regs    (regs),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.duty_write = res_q.duty_write;
	assign res.duty       = res_q.duty;
	assign res.running    = res_q.running;
	assign res.phase      = res_q.phase;

`ifndef SYNTHESIS
	// A duty value is only ever driven while breathing is enabled.
	a_write_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.duty_write |-> res.running)
		else $error("duty write reported while stopped");

	// Results without a duty write carry a zero duty field.
	a_idle_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.duty_write |-> res.duty == '0)
		else $error("nonzero duty without a duty write");

	// A held transaction with a free output register is delivered next cycle.
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("input stage did not advance into a free output register");
`endif

endmodule
`default_nettype wire
